### design/mcfa_pkg.sv
// shared types and constants for the multi-channel frame animator
`default_nettype none

package mcfa_pkg;

  localparam int CHANNELS         = 8;
  localparam int TICKS_PER_SECOND = 50;
  localparam int CH_W             = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHAN_W           = 3;
  localparam int WAIT_W           = 10;
  localparam int FRAMES_W         = 9;
  localparam int FRAME_W          = 8;
  localparam int IMG_W            = 16;
  localparam int POS_W            = 16;
  localparam int IN_DATA_W        = 72;
  localparam int OUT_DATA_W       = 72;

  localparam logic [WAIT_W-1:0] WAIT_CAP = WAIT_W'(TICKS_PER_SECOND * 2);

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STOP  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [2:0] KIND_START_OK   = 3'd0;
  localparam logic [2:0] KIND_START_FAIL = 3'd1;
  localparam logic [2:0] KIND_STOP_DONE  = 3'd2;
  localparam logic [2:0] KIND_DRAW       = 3'd3;
  localparam logic [2:0] KIND_TICK_DONE  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_STOP_SCAN,
    S_STOP_DONE,
    S_TICK_SCAN,
    S_TICK_DONE
  } state_t;

  typedef struct packed {
    logic [IMG_W-1:0]    image;
    logic [WAIT_W-1:0]   period;
    logic [FRAMES_W-1:0] frames;
    logic                bounce;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [WAIT_W-1:0]   remaining;
    logic [FRAME_W-1:0]  frame;
    logic                backward;
  } slot_t;

  typedef struct packed {
    logic            we;
    logic            set_v;
    logic            clr_v;
    logic [CH_W-1:0] idx;
  } slot_wr_t;

  typedef struct packed {
    logic               expired;
    logic [WAIT_W-1:0]  remaining;
    logic [FRAME_W-1:0] frame;
    logic               backward;
    logic [WAIT_W-1:0]  least;
  } step_res_t;

endpackage

`default_nettype wire

### design/multi_channel_frame_animator.sv
// multi_channel_frame_animator: animation slot table with shared tick unit
//
// input channel in_*: one transfer per command; in_tuser[1:0] selects
// start, stop or timer tick, in_tdata carries image id, period, frame
// count, bounce flag and position. result channel out_*: every command
// answers with one or more transfers, out_tuser gives the result kind and
// out_tlast marks the final transfer of the command.
// a start fills the lowest free slot; a stop scans the slots one per cycle
// until the matching image or the last slot; a timer tick walks
// all CHANNELS slots through the single step unit (countdown, frame step,
// minimum), stalling while the output is held, emitting a draw for
// each expired slot in slot order and then a tick done with the next wait.
// in_tready is high only while no command is in progress.
// results sit in one output register; a stalled receiver holds the slot
// walk until the pending transfer is taken, nothing is dropped.
// reset (rst_n low, synchronous) frees every slot and stops the timer.
`default_nettype none

module multi_channel_frame_animator
  import mcfa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // image_id, frame_period, frame_count, bounce_mode, pos_x, pos_y, zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // action
  input  wire logic [1:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // channel, out_image, frame, draw_x, draw_y, next_wait, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // kind
  output logic [2:0]                 out_tuser,
  output logic                       out_tlast
);

  state_t state_r, state_nxt;

  logic [1:0]          act_r, act_nxt;
  logic [IMG_W-1:0]    img_r, img_nxt;
  logic [WAIT_W-1:0]   period_r, period_nxt;
  logic [FRAMES_W-1:0] frames_r, frames_nxt;
  logic                bounce_r, bounce_nxt;
  logic [POS_W-1:0]    x_r, x_nxt;
  logic [POS_W-1:0]    y_r, y_nxt;

  logic [CH_W-1:0]     idx_r, idx_nxt;
  logic [CH_W-1:0]     freed_r, freed_nxt;
  logic [WAIT_W-1:0]   wait_r, wait_nxt;
  logic                running_r, running_nxt;
  logic [WAIT_W-1:0]   least_r, least_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             out_kind_r, out_kind_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;

  slot_wr_t            wr;
  slot_t               wr_data;
  slot_t               rd_data;
  logic [CHANNELS-1:0] valid;
  step_res_t           step;

  logic                in_fire;
  logic                out_free;
  logic                idx_last;
  logic                hit;
  logic                full;
  logic [CH_W-1:0]     free_idx;
  logic [FRAMES_W-1:0] frames_clamped;

  logic                emit;
  logic [2:0]          e_kind;
  logic [CHAN_W-1:0]   e_chan;
  logic [IMG_W-1:0]    e_img;
  logic [FRAME_W-1:0]  e_frame;
  logic [POS_W-1:0]    e_x;
  logic [POS_W-1:0]    e_y;
  logic [WAIT_W-1:0]   e_wait;
  logic                e_last;

  mcfa_slot_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .wr_data (wr_data),
    .rd_idx  (idx_r),
    .rd_data (rd_data),
    .valid   (valid)
  );

  mcfa_step_unit u_step (
    .slot     (rd_data),
    .wait_amt (wait_r),
    .least    (least_r),
    .res      (step)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign idx_last  = (idx_r == CH_W'(CHANNELS - 1));
  assign hit       = valid[idx_r] && (rd_data.image == img_r);
  assign full      = &valid;

  always_comb begin
    free_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = CH_W'(i);
      end
    end
  end

  always_comb begin
    frames_clamped = frames_r;
    if (frames_r == '0) begin
      frames_clamped = FRAMES_W'(1);
    end else if (frames_r > FRAMES_W'(256)) begin
      frames_clamped = FRAMES_W'(256);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            ACT_START: state_nxt = S_START;
            ACT_STOP:  state_nxt = S_STOP_SCAN;
            ACT_TICK:  state_nxt = running_r ? S_TICK_SCAN : S_TICK_DONE;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_START: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_STOP_SCAN: begin
        if (hit || idx_last) state_nxt = S_STOP_DONE;
      end
      S_STOP_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_TICK_SCAN: begin
        if (out_free && idx_last) state_nxt = S_TICK_DONE;
      end
      S_TICK_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    act_nxt     = act_r;
    img_nxt     = img_r;
    period_nxt  = period_r;
    frames_nxt  = frames_r;
    bounce_nxt  = bounce_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    idx_nxt     = idx_r;
    freed_nxt   = freed_r;
    wait_nxt    = wait_r;
    running_nxt = running_r;
    least_nxt   = least_r;

    wr       = '0;
    wr_data  = rd_data;

    emit    = 1'b0;
    e_kind  = KIND_TICK_DONE;
    e_chan  = '0;
    e_img   = '0;
    e_frame = '0;
    e_x     = '0;
    e_y     = '0;
    e_wait  = '0;
    e_last  = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          act_nxt    = in_tuser;
          img_nxt    = in_tdata[15:0];
          period_nxt = in_tdata[25:16];
          frames_nxt = in_tdata[34:26];
          bounce_nxt = in_tdata[35];
          x_nxt      = in_tdata[51:36];
          y_nxt      = in_tdata[67:52];
          idx_nxt    = '0;
          freed_nxt  = '0;
          least_nxt  = WAIT_CAP;
        end
      end
      S_START: begin
        if (out_free) begin
          emit = 1'b1;
          if (full) begin
            e_kind = KIND_START_FAIL;
            e_wait = running_r ? wait_r : '0;
          end else begin
            wr.we              = 1'b1;
            wr.set_v           = 1'b1;
            wr.idx             = free_idx;
            wr_data.image      = img_r;
            wr_data.period     = period_r;
            wr_data.frames     = frames_clamped;
            wr_data.bounce     = bounce_r;
            wr_data.pos_x      = x_r;
            wr_data.pos_y      = y_r;
            wr_data.remaining  = period_r;
            wr_data.frame      = '0;
            wr_data.backward   = 1'b0;
            if (!running_r) begin
              wait_nxt    = (period_r > WAIT_W'(1)) ? period_r : WAIT_W'(1);
              running_nxt = 1'b1;
            end
            e_kind = KIND_START_OK;
            e_chan = CHAN_W'(free_idx);
            e_wait = wait_nxt;
          end
        end
      end
      S_STOP_SCAN: begin
        if (hit) begin
          wr.clr_v  = 1'b1;
          wr.idx    = idx_r;
          freed_nxt = idx_r;
        end else if (!idx_last) begin
          idx_nxt = idx_r + CH_W'(1);
        end
      end
      S_STOP_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          if (valid == '0) begin
            running_nxt = 1'b0;
          end
          e_kind = KIND_STOP_DONE;
          e_chan = CHAN_W'(freed_r);
          e_wait = running_nxt ? wait_r : '0;
        end
      end
      S_TICK_SCAN: begin
        if (out_free) begin
          if (valid[idx_r]) begin
            wr.we             = 1'b1;
            wr.idx            = idx_r;
            wr_data.remaining = step.remaining;
            wr_data.frame     = step.frame;
            wr_data.backward  = step.backward;
            least_nxt         = step.least;
            if (step.expired) begin
              emit    = 1'b1;
              e_kind  = KIND_DRAW;
              e_chan  = CHAN_W'(idx_r);
              e_img   = rd_data.image;
              e_frame = step.frame;
              e_x     = rd_data.pos_x;
              e_y     = rd_data.pos_y;
              e_wait  = '0;
              e_last  = 1'b0;
            end
          end
          if (!idx_last) begin
            idx_nxt = idx_r + CH_W'(1);
          end
        end
      end
      S_TICK_DONE: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = KIND_TICK_DONE;
          if (running_r) begin
            wait_nxt = (least_r == '0) ? WAIT_W'(1) : least_r;
            e_wait   = wait_nxt;
          end
        end
      end
      default: begin
      end
    endcase

    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = e_kind;
      out_data_nxt  = {3'b000, e_wait, e_y, e_x, e_frame, e_img, e_chan};
      out_last_nxt  = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= 1'b0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    img_r      <= img_nxt;
    period_r   <= period_nxt;
    frames_r   <= frames_nxt;
    bounce_r   <= bounce_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    idx_r      <= idx_nxt;
    freed_r    <= freed_nxt;
    least_r    <= least_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### design/mcfa_slot_store.sv
// slot register file with per-slot valid bits
`default_nettype none

module mcfa_slot_store
  import mcfa_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire slot_wr_t        wr,
  input  wire slot_t           wr_data,
  input  wire logic [CH_W-1:0] rd_idx,
  output slot_t                rd_data,
  output logic [CHANNELS-1:0]  valid
);

  slot_t               slots_r [CHANNELS];
  logic [CHANNELS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      slots_r[wr.idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.set_v) begin
      valid_r[wr.idx] <= 1'b1;
    end else if (wr.clr_v) begin
      valid_r[wr.idx] <= 1'b0;
    end
  end

  assign rd_data = slots_r[rd_idx];
  assign valid   = valid_r;

endmodule

`default_nettype wire

### design/mcfa_step_unit.sv
// shared per-slot tick unit: countdown, frame step and running minimum
`default_nettype none

module mcfa_step_unit
  import mcfa_pkg::*;
(
  input  wire slot_t             slot,
  input  wire logic [WAIT_W-1:0] wait_amt,
  input  wire logic [WAIT_W-1:0] least,
  output step_res_t              res
);

  logic signed [WAIT_W:0]    diff;
  logic signed [WAIT_W:0]    f1;
  logic signed [WAIT_W:0]    f2;
  logic signed [WAIT_W:0]    top_frame;
  logic                      expired;
  logic                      out_range;
  logic                      back_n;
  logic [WAIT_W-1:0]         rem_n;
  logic [FRAME_W-1:0]        frame_n;

  always_comb begin
    diff      = $signed({1'b0, slot.remaining}) - $signed({1'b0, wait_amt});
    expired   = (diff <= 0);
    top_frame = $signed({2'b00, slot.frames}) - 11'sd1;
    f1        = slot.backward ? $signed({3'b000, slot.frame}) - 11'sd1
                              : $signed({3'b000, slot.frame}) + 11'sd1;
    out_range = (f1 > top_frame) || (f1 < 0);
    back_n    = slot.backward;
    f2        = f1;
    if (out_range) begin
      if (slot.bounce) begin
        back_n = ~slot.backward;
        f2     = back_n ? f1 - 11'sd2 : f1 + 11'sd2;
        if (f2 < 0) begin
          f2 = '0;
        end
        if (f2 > top_frame) begin
          f2 = top_frame;
        end
      end else begin
        f2 = '0;
      end
    end
    frame_n = f2[FRAME_W-1:0];
    rem_n   = expired ? slot.period : diff[WAIT_W-1:0];

    res.expired   = expired;
    res.remaining = rem_n;
    res.frame     = expired ? frame_n : slot.frame;
    res.backward  = expired ? back_n : slot.backward;
    res.least     = (rem_n < least) ? rem_n : least;
  end

endmodule

`default_nettype wire
